// File: hdl/fftr_pkg.sv
// fftr_pkg: shared constants, types and the sine rom builder of the twiddle rotator
// used by every module of the block; depends on nothing
package fftr_pkg;

   localparam int MAX_DIMS         = 3;
   localparam int NUM_SETUP        = 3;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int ROM_AW           = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int TI_W             = $clog2(SINE_TABLE_DEPTH) + 2;
   localparam int DIM_W            = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   localparam int SAMPLE_W = 24;
   localparam int SETUP_W  = 48;
   localparam int ND_W     = 2;
   localparam int IDX_W    = 12;
   localparam int ELEMS_W  = 12;
   localparam int PROCS_W  = 8;
   localparam int LOC_W    = 8;
   localparam int JOBS_W   = 12;
   localparam int PIDX_W   = 8;
   localparam int PHASE_W  = 16;
   localparam int MOD_W    = ELEMS_W + PROCS_W;
   localparam int DVD_W    = MOD_W + PHASE_W;
   localparam int SIN_W    = 24;

   localparam logic [1:0] CSR_NUM_DIMS   = 2'd0;
   localparam logic [1:0] CSR_DIM0_SETUP = 2'd1;
   localparam logic [1:0] CSR_DIM1_SETUP = 2'd2;
   localparam logic [1:0] CSR_DIM2_SETUP = 2'd3;

   // (2n+2)*(2n+3) for each term of the series
   localparam longint unsigned TAYLOR_DIV [12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   typedef struct packed {
      logic [ND_W-1:0]                   num_dims;
      logic [NUM_SETUP-1:0][SETUP_W-1:0] setup;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] re;
      logic [SAMPLE_W-1:0] im;
   } sample_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [MOD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quot;
      logic [MOD_W-1:0] rem;
   } div_rsp_type;

   typedef logic [SIN_W-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // q30 taylor series of sin over a quarter wave, truncating at each step
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint sum;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (64'd1686629713 * longint'(i)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = 0;
         for (int n = 0; n < 12; n++) begin
            if (n % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
         end
         if (sum < 0) sum = 0;
         v = ((longint'(sum) << 23) + (64'd1 << 29)) >> 30;
         if (v > 64'd8388608) v = 64'd8388608;
         rom[i] = v[SIN_W-1:0];
      end
      return rom;
   endfunction

endpackage

// File: hdl/fft_twiddle_rotator.sv
// fft_twiddle_rotator: top level with the register file, input queue, sequencer and divider
// depends on fftr_pkg, fftr_front, fftr_div and fftr_back
//
// Rotates each complex Q1.23 word by the twiddle factor of a multidimensional
// four-step FFT walk and flags the final word of the walk on rsp_run_last. Words
// enter a four-entry queue and are processed one at a time; the sequencer takes each
// dimension in use through two prep states, and for every one with a nonzero modulus
// runs two divisions on the bit-serial divider, one for the index modulus and one
// for the phase fraction. The finished word waits in an output register while the
// next one is worked on. Registers are written through csr_we/csr_index/csr_wdata;
// the user must write them only while the block is idle; the block does not enforce it.
module fft_twiddle_rotator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [fftr_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [fftr_pkg::SAMPLE_W-1:0]  req_sample_im,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [fftr_pkg::SAMPLE_W-1:0]  rsp_rotated_re,
   output logic signed [fftr_pkg::SAMPLE_W-1:0]  rsp_rotated_im,
   output logic                                  rsp_run_last,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [fftr_pkg::SETUP_W-1:0]          csr_wdata
);
   import fftr_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   sample_type  push_data, head;
   logic        q_empty, q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_DIMS:   cfg_in.num_dims = csr_wdata[ND_W-1:0];
            CSR_DIM0_SETUP: cfg_in.setup[0] = csr_wdata;
            CSR_DIM1_SETUP: cfg_in.setup[1] = csr_wdata;
            CSR_DIM2_SETUP: cfg_in.setup[2] = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_dims <= ND_W'(1);
         cfg_ff.setup    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign push_data.re = req_sample_re;
   assign push_data.im = req_sample_im;

   fftr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_data (push_data),
      .empty     (q_empty),
      .pop       (q_pop),
      .head      (head)
   );

   fftr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fftr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_head         (head),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_rotated_re (rsp_rotated_re),
      .rsp_rotated_im (rsp_rotated_im),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

// File: hdl/fftr_front.sv
// fftr_front: input word queue between the request port and the rotation engine
// depends on fftr_pkg
module fftr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  fftr_pkg::sample_type push_data,
   output logic                empty,
   input  logic                pop,
   output fftr_pkg::sample_type head
);
   import fftr_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   sample_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == (PTR_W + 1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/fftr_div.sv
// fftr_div: bit-serial restoring divider, one quotient bit per cycle
// depends on fftr_pkg
module fftr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fftr_pkg::div_req_type req,
   output fftr_pkg::div_rsp_type rsp
);
   import fftr_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [MOD_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [MOD_W:0]   shifted, diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      ge      = (shifted >= {1'b0, dsr_ff});
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

// File: hdl/fftr_back.sv
// fftr_back: sequencer that walks the multi-index, builds the phase and rotates a word
// depends on fftr_pkg; drives fftr_div through a request struct
module fftr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  fftr_pkg::cfg_type              cfg,
   input  logic                           q_empty,
   output logic                           q_pop,
   input  fftr_pkg::sample_type           q_head,
   output fftr_pkg::div_req_type          div_req,
   input  fftr_pkg::div_rsp_type          div_rsp,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic signed [fftr_pkg::SAMPLE_W-1:0] rsp_rotated_re,
   output logic signed [fftr_pkg::SAMPLE_W-1:0] rsp_rotated_im,
   output logic                           rsp_run_last
);
   import fftr_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_PREP1    = 13'b0000000000010,
      ST_PREP2    = 13'b0000000000100,
      ST_DIV_MOD  = 13'b0000000001000,
      ST_DIV_FRAC = 13'b0000000010000,
      ST_TAB0     = 13'b0000000100000,
      ST_TAB1     = 13'b0000001000000,
      ST_TAB2     = 13'b0000010000000,
      ST_MUL0     = 13'b0000100000000,
      ST_MUL1     = 13'b0001000000000,
      ST_MUL2     = 13'b0010000000000,
      ST_MUL3     = 13'b0100000000000,
      ST_DONE     = 13'b1000000000000
   } state_type;

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam int ACC_W = 2 * SAMPLE_W + 2;
   localparam int PRD_W = 2 * SAMPLE_W + 1;

   state_type state_ff, state_in;

   logic [MAX_DIMS-1:0][IDX_W-1:0] idx_ff, idx_in, cur_idx_ff;
   logic [MAX_DIMS-1:0][IDX_W-1:0] idx_next;
   logic [DIM_W-1:0]  dim_ff, dim_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [MOD_W-1:0]  xs_ff, m_ff;
   logic signed [SAMPLE_W-1:0] re_ff, im_ff, ore_ff, oim_ff;
   logic [SIN_W-1:0]  rom_q_ff, a_ff, b_ff;
   logic [ROM_AW-1:0] rom_addr;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic              last_ff, last_now;
   logic              out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_re_ff, out_im_ff;
   logic              out_last_ff;

   logic [ND_W-1:0]   n_use;
   logic [SETUP_W-1:0] setup;
   logic [ELEMS_W-1:0] elems;
   logic [PROCS_W-1:0] procs;
   logic [LOC_W-1:0]   loc;
   logic [PIDX_W-1:0]  pidx;
   logic               last_dim;
   logic [TI_W-1:0]    ti;
   logic [1:0]         quad;
   logic [TI_W-3:0]    rpos;
   logic signed [SIN_W:0] sn, cs, a_s, b_s;
   logic signed [SAMPLE_W-1:0] mul_a;
   logic signed [SIN_W:0]      mul_b;
   logic signed [PRD_W-1:0]    prod;
   logic signed [ACC_W-1:0]    prod_x, acc_sum, acc_dif;
   logic                       load_out;

   function automatic logic signed [SAMPLE_W-1:0] round_sat(logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      logic signed [ACC_W-24:0] sh;
      t  = acc + ACC_W'(64'sd4194304);
      sh = t[ACC_W-1:23];
      if (sh > (ACC_W - 23)'(64'sd8388607))       return 24'sh7FFFFF;
      else if (sh < -(ACC_W - 23)'(64'sd8388608)) return 24'sh800000;
      else                                        return sh[SAMPLE_W-1:0];
   endfunction

   // dims in use: zero acts as one, larger values clamp
   always_comb begin
      if (cfg.num_dims == '0)                        n_use = ND_W'(1);
      else if (cfg.num_dims > ND_W'(MAX_DIMS))       n_use = ND_W'(MAX_DIMS);
      else                                           n_use = cfg.num_dims;
   end

   // walk advance, last dimension fastest
   always_comb begin
      logic carry;
      logic at_end;
      carry    = 1'b1;
      last_now = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         at_end = ({1'b0, idx_ff[d]} + 1'b1) >= {1'b0, cfg.setup[d][39:28]};
         idx_next[d] = idx_ff[d];
         if (d < int'(n_use)) begin
            if (!at_end) last_now = 1'b0;
            if (carry) begin
               if (at_end) idx_next[d] = '0;
               else begin
                  idx_next[d] = idx_ff[d] + 1'b1;
                  carry       = 1'b0;
               end
            end
         end else begin
            idx_next[d] = '0;
         end
      end
   end

   always_comb begin
      setup    = cfg.setup[dim_ff];
      elems    = setup[11:0];
      procs    = setup[19:12];
      loc      = setup[27:20];
      pidx     = setup[47:40];
      last_dim = (dim_ff == DIM_W'(n_use - 1'b1));
      ti       = phase_ff[PHASE_W-1 -: TI_W];
      quad     = ti[TI_W-1 -: 2];
      rpos     = ti[TI_W-3:0];
      a_s      = $signed({1'b0, a_ff});
      b_s      = $signed({1'b0, b_ff});
      unique case (quad)
         2'd0: begin sn = a_s;  cs = b_s;  end
         2'd1: begin sn = b_s;  cs = -a_s; end
         2'd2: begin sn = -a_s; cs = -b_s; end
         default: begin sn = -b_s; cs = a_s; end
      endcase
      rom_addr = (state_ff == ST_TAB1) ? ROM_AW'(SINE_TABLE_DEPTH) - ROM_AW'(rpos)
                                       : ROM_AW'(rpos);
   end

   // one shared multiplier across the four products
   always_comb begin
      mul_a = re_ff;
      mul_b = cs;
      unique case (state_ff)
         ST_MUL1: begin mul_a = im_ff; mul_b = sn; end
         ST_MUL2: begin mul_a = im_ff; mul_b = cs; end
         ST_MUL3: begin mul_a = re_ff; mul_b = sn; end
         default: begin mul_a = re_ff; mul_b = cs; end
      endcase
      prod    = mul_a * mul_b;
      prod_x  = ACC_W'(prod);
      acc_sum = acc_ff + prod_x;
      acc_dif = acc_ff - prod_x;
   end

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      dim_in           = dim_ff;
      phase_in         = phase_ff;
      acc_in           = acc_ff;
      q_pop            = 1'b0;
      load_out         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DVD_W'(pidx) * DVD_W'(xs_ff);
      div_req.divisor  = m_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               idx_in   = idx_next;
               dim_in   = '0;
               phase_in = '0;
               state_in = ST_PREP1;
            end
         end
         ST_PREP1: state_in = ST_PREP2;
         ST_PREP2: begin
            if (m_ff == '0) begin
               // zero modulus adds no phase
               if (last_dim) state_in = ST_TAB0;
               else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = ST_PREP1;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV_MOD;
            end
         end
         ST_DIV_MOD: begin
            div_req.dividend = {div_rsp.rem, PHASE_W'(0)} + DVD_W'(m_ff >> 1);
            if (div_rsp.done) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV_FRAC;
            end
         end
         ST_DIV_FRAC: begin
            if (div_rsp.done) begin
               phase_in = phase_ff + div_rsp.quot[PHASE_W-1:0];
               if (last_dim) state_in = ST_TAB0;
               else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = ST_PREP1;
               end
            end
         end
         ST_TAB0: state_in = ST_TAB1;
         ST_TAB1: state_in = ST_TAB2;
         ST_TAB2: state_in = ST_MUL0;
         ST_MUL0: begin
            acc_in   = prod_x;
            state_in = ST_MUL1;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: begin
            acc_in   = prod_x;
            state_in = ST_MUL3;
         end
         ST_MUL3: state_in = ST_DONE;
         ST_DONE: begin
            if (!out_valid_ff) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = load_out ? 1'b1 : (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dim_ff   <= dim_in;
      phase_ff <= phase_in;
      acc_ff   <= acc_in;
      rom_q_ff <= SINE_ROM[rom_addr];
      if (q_pop) begin
         re_ff      <= $signed(q_head.re);
         im_ff      <= $signed(q_head.im);
         cur_idx_ff <= idx_ff;
         last_ff    <= last_now;
      end
      if (state_ff == ST_PREP1) begin
         xs_ff <= MOD_W'(cur_idx_ff[dim_ff]) * MOD_W'(procs) + MOD_W'(loc);
         m_ff  <= MOD_W'(elems) * MOD_W'(procs);
      end
      if (state_ff == ST_TAB1) a_ff <= rom_q_ff;
      if (state_ff == ST_TAB2) b_ff <= rom_q_ff;
      if (state_ff == ST_MUL1) ore_ff <= round_sat(acc_sum);
      if (state_ff == ST_MUL3) oim_ff <= round_sat(acc_dif);
      if (load_out) begin
         out_re_ff   <= ore_ff;
         out_im_ff   <= oim_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_rotated_re = out_re_ff;
   assign rsp_rotated_im = out_im_ff;
   assign rsp_run_last   = out_last_ff;

endmodule
